>>> design/assert_macros.svh
// assert_macros.svh: assertion macros used by snp_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on rising clk, ignored while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// property checked on rising clk, also during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/snp_pkg.sv
// snp_pkg: types, codes and constants of the size number parser
// used by snp_step, size_number_parser and snp_checker

package snp_pkg;

	localparam int CH_W    = 8;
	localparam int VALUE_W = 32;
	localparam int OUTC_W  = 2;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_ZERO  = 2'd1,
		PH_BODY  = 2'd2,
		PH_DROP  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_HEX = 2'd2,
		RADIX_RSV = 2'd3
	} radix_t;

	localparam logic [OUTC_W-1:0] OUTC_NUL     = 2'd0;
	localparam logic [OUTC_W-1:0] OUTC_COMMA   = 2'd1;
	localparam logic [OUTC_W-1:0] OUTC_SPACE   = 2'd2;
	localparam logic [OUTC_W-1:0] OUTC_INVALID = 2'd3;

	localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CH_W-1:0] CH_COMMA = 8'h2c;
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [VALUE_W-1:0] accum;
		radix_t             radix;
		phase_t             phase;
	} parse_state_t;

	typedef struct packed {
		logic               emit;
		logic [VALUE_W-1:0] value;
		logic [OUTC_W-1:0]  outcome;
	} step_res_t;

	localparam parse_state_t STATE_RESET = '{accum: '0, radix: RADIX_DEC, phase: PH_START};

endpackage

>>> design/snp_step.sv
// snp_step: one-character update of the parser state and result decode
// depends on snp_pkg

module snp_step (
	input  logic [snp_pkg::CH_W-1:0] ch,
	input  snp_pkg::parse_state_t    cur,
	output snp_pkg::parse_state_t    nxt,
	output snp_pkg::step_res_t       res
);

	logic                        is_term;
	logic [snp_pkg::OUTC_W-1:0]  term_code;
	logic                        is_digit;
	logic [3:0]                  digit;
	logic                        use_body;
	snp_pkg::radix_t             radix_eff;
	logic [snp_pkg::VALUE_W-1:0] acc;
	logic [snp_pkg::VALUE_W-1:0] scaled;

	always_comb begin
		is_term   = 1'b1;
		term_code = snp_pkg::OUTC_NUL;
		case (ch)
			snp_pkg::CH_NUL:   term_code = snp_pkg::OUTC_NUL;
			snp_pkg::CH_COMMA: term_code = snp_pkg::OUTC_COMMA;
			snp_pkg::CH_SPACE: term_code = snp_pkg::OUTC_SPACE;
			default:           is_term   = 1'b0;
		endcase
	end

	always_comb begin
		is_digit = 1'b1;
		digit    = '0;
		if (ch inside {["0":"9"]}) begin
			digit = 4'(ch - 8'h30);
		end else if (ch inside {["a":"f"]}) begin
			digit = 4'(ch - 8'h57);
		end else if (ch inside {["A":"F"]}) begin
			digit = 4'(ch - 8'h37);
		end else begin
			is_digit = 1'b0;
		end
	end

	always_comb begin
		acc = cur.accum;
		case (radix_eff)
			snp_pkg::RADIX_OCT: scaled = acc << 3;
			snp_pkg::RADIX_HEX: scaled = acc << 4;
			default:            scaled = (acc << 3) + (acc << 1);
		endcase
	end

	always_comb begin
		nxt       = cur;
		res       = '{emit: 1'b0, value: '0, outcome: snp_pkg::OUTC_NUL};
		use_body  = 1'b0;
		radix_eff = cur.radix;
		case (cur.phase)
			snp_pkg::PH_START: begin
				if (ch == 8'h30) begin
					nxt.accum = '0;
					nxt.radix = snp_pkg::RADIX_OCT;
					nxt.phase = snp_pkg::PH_ZERO;
				end else begin
					radix_eff = snp_pkg::RADIX_DEC;
					use_body  = 1'b1;
				end
			end
			snp_pkg::PH_ZERO: begin
				if (ch == 8'h78 || ch == 8'h58) begin
					nxt.radix = snp_pkg::RADIX_HEX;
					nxt.phase = snp_pkg::PH_BODY;
				end else begin
					use_body = 1'b1;
				end
			end
			snp_pkg::PH_BODY: use_body = 1'b1;
			default: begin
				if (is_term) begin
					nxt = snp_pkg::STATE_RESET;
				end
			end
		endcase

		if (use_body) begin
			nxt.radix = radix_eff;
			nxt.phase = snp_pkg::PH_BODY;
			if (is_term) begin
				res = '{emit: 1'b1, value: cur.accum, outcome: term_code};
				nxt = snp_pkg::STATE_RESET;
			end else if (is_digit) begin
				nxt.accum = scaled + snp_pkg::VALUE_W'(digit);
			end else if (ch == 8'h6b || ch == 8'h4b) begin
				nxt.accum = cur.accum << 10;
			end else if (ch == 8'h6d || ch == 8'h4d) begin
				nxt.accum = cur.accum << 20;
			end else if (ch == 8'h67 || ch == 8'h47) begin
				nxt.accum = cur.accum << 30;
			end else begin
				res = '{emit: 1'b1, value: '0, outcome: snp_pkg::OUTC_INVALID};
				nxt = '{accum: '0, radix: snp_pkg::RADIX_DEC, phase: snp_pkg::PH_DROP};
			end
		end
	end

endmodule

>>> design/size_number_parser.sv
// size_number_parser: top level of the character-serial size number parser
// depends on snp_pkg and snp_step

// Takes one character per word and returns one word per number: the value
// modulo 2^32 and how it ended (NUL, comma, space or invalid character).
// A leading 0 selects octal, 0x/0X hex, else decimal; k/m/g shift left by
// 10/20/30. After an invalid character, input is dropped up to and including
// the next terminator. One character is taken every cycle unless input
// stalls; a character moves from the input register through the state
// update to the result register. Input stalls only while a result word
// waits unaccepted in the output register and the character in the input
// register would produce another one.

module size_number_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] value
	output logic [1:0]  m_tuser    // [1:0] outcome
);

	logic [snp_pkg::CH_W-1:0]    ch_s1;
	logic                        vld_s1;
	snp_pkg::parse_state_t       state_q;
	snp_pkg::parse_state_t       state_nxt;
	snp_pkg::step_res_t          res;
	logic [snp_pkg::VALUE_W-1:0] value_q;
	logic [snp_pkg::OUTC_W-1:0]  outcome_q;
	logic                        out_vld_q;
	logic                        advance;

	snp_step u_step (
		.ch  (ch_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.res (res)
	);

	assign advance  = vld_s1 && (!res.emit || !out_vld_q || m_tready);
	assign s_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= snp_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance && res.emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			value_q   <= res.value;
			outcome_q <= res.outcome;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = value_q;
	assign m_tuser  = outcome_q;

endmodule

>>> design/snp_checker.sv
// snp_checker: port-level assertions for size_number_parser, bound to it
// depends on snp_pkg and assert_macros.svh
`include "assert_macros.svh"

module snp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);

	`ASSERT_CLK(a_out_hold, clk, arst_n,
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
		"result word changed while stalled")
	`ASSERT_CLK(a_in_hold, clk, arst_n,
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata),
		"input word changed while stalled")
	`ASSERT_CLK(a_invalid_zero, clk, arst_n,
		m_tvalid && m_tuser == snp_pkg::OUTC_INVALID |-> m_tdata == '0,
		"invalid result with nonzero value")
	`ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind size_number_parser snp_checker u_snp_checker (.*);
